/* src/cpvm_pkg.sv */
// Shared constants and types for the camera pose / view matrix block.
// Used by the top level and by its port checker; depends on nothing.
`default_nettype none
package cpvm_pkg;

  localparam int IN_DATA_W  = 160;  // delta_x, delta_y, delta_z, quat_w..quat_z
  localparam int OUT_DATA_W = 80;   // col_x, col_y, col_z, offset
  localparam int CFG_W      = 32;
  localparam int ABS_W      = 52;   // magnitude of an unnormalized rotated component

  localparam logic [1:0] MODE_TRANSLATE = 2'd0;
  localparam logic [1:0] MODE_ROTATE    = 2'd1;
  localparam logic [1:0] MODE_RESTORE   = 2'd2;
  localparam logic [1:0] MODE_HOLD      = 2'd3;

  // Row codes double as axis indexes of the pose.
  localparam logic [1:0] ROW_RIGHT = 2'd0;
  localparam logic [1:0] ROW_UP    = 2'd1;
  localparam logic [1:0] ROW_FWD   = 2'd2;

  localparam logic [1:0] REG_START_X  = 2'd0;
  localparam logic [1:0] REG_START_Y  = 2'd1;
  localparam logic [1:0] REG_START_Z  = 2'd2;
  localparam logic [1:0] REG_ZERO_THR = 2'd3;

  localparam logic signed [15:0] AXIS_ONE = 16'sd16384;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LEN,
    S_CHECK,
    S_ROT,
    S_NORM,
    S_SQ,
    S_SQRT,
    S_DIV,
    S_CROSS,
    S_EMIT
  } state_t;

endpackage
`default_nettype wire

/* src/camera_pose_view_matrix.sv */
// Camera pose keeper and view matrix row generator, top level.
// Depends on cpvm_pkg.
`default_nettype none
// The block holds a camera pose (Q16.16 position, Q2.14 right/up/forward
// axes) and updates it by one input transfer at a time: mode 0 adds a
// saturating translation, mode 1 rotates forward and up by the sandwich
// product q*v*conj(q), renormalizes them and rebuilds right = up x forward,
// mode 2 restores the start position and the unit axes, mode 3 leaves the
// pose alone. A quaternion whose squared length is below zero_threshold is
// ignored. After every input the block sends three output transfers, rows
// right, up and forward, each [axis, -dot(axis, position)], the forward row
// with tlast set. All arithmetic runs through one 16 x 34 bit multiplier with
// a 64 bit accumulator, an iterative square root (one result bit a cycle)
// and a restoring divider (one quotient bit a cycle). Translate, restore and
// no-op items go straight to emission (per row a dot product and an output
// load), an ignored rotate only after the length check; a rotate's time is
// set mostly by the square root and the three divisions per axis, plus the
// normalizing shifts per axis. Output stalls add to this.
// s_tready is high only while the sequencer is idle; the
// output register lets the next input enter while the last row still waits.
// Configuration writes are expected only while the block is idle.
module camera_pose_view_matrix (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // delta_x[31:0], delta_y[63:32], delta_z[95:64],
  // quat_w[111:96], quat_x[127:112], quat_y[143:128], quat_z[159:144]
  input  logic [cpvm_pkg::IN_DATA_W-1:0] s_tdata,
  // mode[1:0]
  input  logic [1:0]                     s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // col_x[15:0], col_y[31:16], col_z[47:32], offset[79:48]
  output logic [cpvm_pkg::OUT_DATA_W-1:0] m_tdata,
  // row_index[1:0]
  output logic [1:0]                     m_tuser,
  output logic                           m_tlast,
  input  logic                           cfg_wen,
  input  logic [1:0]                     cfg_index,
  input  logic [cpvm_pkg::CFG_W-1:0]     cfg_data
);
  import cpvm_pkg::*;

  // Round a Q.28 style value to Q.14, ties away from zero.
  function automatic logic signed [63:0] rnd14(input logic signed [63:0] v);
    logic [63:0] m;
    m = v[63] ? 64'(-v) : 64'(v);
    m = (m + 64'd8192) >> 14;
    return v[63] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
    if (v > 64'sd32767) return 16'sh7fff;
    else if (v < -64'sd32768) return 16'sh8000;
    else return v[15:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    else if (v < -64'sd2147483648) return 32'sh80000000;
    else return v[31:0];
  endfunction

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] p,
                                                 input logic signed [31:0] d);
    logic signed [32:0] sum;
    sum = 33'(p) + 33'(d);
    if (sum[32] != sum[31]) return sum[32] ? 32'sh80000000 : 32'sh7fffffff;
    else return sum[31:0];
  endfunction

  // Control and pose
  state_t      state, state_next;
  logic [4:0]  step, step_next;
  logic [1:0]  k, k_next;      // axis under rotation
  logic [1:0]  ci, ci_next;    // component under division
  logic [1:0]  row, row_next;  // row under emission

  logic signed [31:0] start_x, start_y, start_z;
  logic [15:0]        zero_threshold;
  logic signed [31:0] pos [3];
  logic signed [15:0] axis [3][3];  // [axis][component]

  // Datapath
  logic signed [15:0] qw, qx, qy, qz;
  logic signed [63:0] acc, acc_next;
  logic signed [33:0] sq3, s_term, dot;
  logic signed [33:0] cr [3];
  logic [ABS_W-1:0]   a [3];
  logic [2:0]         sgn;
  logic [63:0]        rem, res, sbit;
  logic [31:0]        drem;
  logic [15:0]        dlo, dq;

  // Shared multiply-accumulate controls
  logic               mac_en, mac_clr, mac_sub;
  logic [3:0]         mac_sh;
  logic signed [15:0] mul_a;
  logic signed [33:0] mul_b;
  logic signed [49:0] prod;
  logic signed [63:0] term;
  logic               out_load;

  logic [1:0]         ax_sel, a_idx;
  logic signed [15:0] v0, v1, v2;
  logic [ABS_W-1:0]   a_sel;
  logic               sgn_sel;
  logic signed [63:0] len2;
  logic               a_zero, a_high, a_low;
  logic [63:0]        sq_t;
  logic [32:0]        div_t;
  logic [44:0]        num;
  logic [63:0]        acc_abs;

  assign s_tready = (state == S_IDLE);

  assign prod     = mul_a * mul_b;
  assign term     = 64'(prod) <<< mac_sh;
  assign acc_next = mac_clr ? term : (mac_sub ? acc - term : acc + term);
  assign acc_abs  = acc[63] ? 64'(-acc) : 64'(acc);

  // One axis read port: the row while emitting, else the rotated axis
  assign ax_sel = (state == S_EMIT) ? row : k;
  always_comb begin
    case (ax_sel)
      ROW_RIGHT: begin v0 = axis[0][0]; v1 = axis[0][1]; v2 = axis[0][2]; end
      ROW_UP:    begin v0 = axis[1][0]; v1 = axis[1][1]; v2 = axis[1][2]; end
      default:   begin v0 = axis[2][0]; v1 = axis[2][1]; v2 = axis[2][2]; end
    endcase
  end

  assign a_idx = (state == S_SQ) ? step[2:1] : ci;
  always_comb begin
    case (a_idx)
      2'd0:    begin a_sel = a[0]; sgn_sel = sgn[0]; end
      2'd1:    begin a_sel = a[1]; sgn_sel = sgn[1]; end
      default: begin a_sel = a[2]; sgn_sel = sgn[2]; end
    endcase
  end

  assign len2   = acc + 64'(sq3);
  assign a_zero = (a[0] == '0) && (a[1] == '0) && (a[2] == '0);
  assign a_high = (|a[0][ABS_W-1:30]) | (|a[1][ABS_W-1:30]) | (|a[2][ABS_W-1:30]);
  assign a_low  = !((|a[0][ABS_W-1:29]) | (|a[1][ABS_W-1:29]) | (|a[2][ABS_W-1:29]));
  assign sq_t   = res + sbit;
  assign div_t  = {drem, dlo[15]};
  assign num    = {1'b0, a_sel[29:0], 14'd0} + 45'(res[31:1]);

  // Sequencer
  always_comb begin
    state_next = state;
    step_next  = step + 5'd1;
    k_next     = k;
    ci_next    = ci;
    row_next   = row;
    mac_en     = 1'b0;
    mac_clr    = 1'b0;
    mac_sub    = 1'b0;
    mac_sh     = 4'd0;
    mul_a      = '0;
    mul_b      = '0;
    out_load   = 1'b0;
    case (state)
      S_IDLE: begin
        step_next = '0;
        if (s_tvalid) begin
          row_next   = ROW_RIGHT;
          state_next = (s_tuser == MODE_ROTATE) ? S_LEN : S_EMIT;
        end
      end
      // x^2+y^2+z^2, then w^2 with the first sum held aside
      S_LEN: begin
        mac_en = 1'b1;
        case (step)
          5'd0: begin mac_clr = 1'b1; mul_a = qx; mul_b = 34'(qx); end
          5'd1: begin mul_a = qy; mul_b = 34'(qy); end
          5'd2: begin mul_a = qz; mul_b = 34'(qz); end
          default: begin
            mac_clr = 1'b1; mul_a = qw; mul_b = 34'(qw);
            state_next = S_CHECK;
          end
        endcase
      end
      S_CHECK: begin
        step_next = '0;
        if (len2 < 64'(zero_threshold)) begin
          state_next = S_EMIT;
          row_next   = ROW_RIGHT;
        end else begin
          state_next = S_ROT;
          k_next     = ROW_FWD;
        end
      end
      // dot(u,v), cross(u,v), then each rotated component unscaled
      S_ROT: begin
        mac_en = 1'b1;
        case (step)
          5'd0:  begin mac_clr = 1'b1; mul_a = qx; mul_b = 34'(v0); end
          5'd1:  begin mul_a = qy; mul_b = 34'(v1); end
          5'd2:  begin mul_a = qz; mul_b = 34'(v2); end
          5'd3:  begin mac_clr = 1'b1; mul_a = qy; mul_b = 34'(v2); end
          5'd4:  begin mac_sub = 1'b1; mul_a = qz; mul_b = 34'(v1); end
          5'd5:  begin mac_clr = 1'b1; mul_a = qz; mul_b = 34'(v0); end
          5'd6:  begin mac_sub = 1'b1; mul_a = qx; mul_b = 34'(v2); end
          5'd7:  begin mac_clr = 1'b1; mul_a = qx; mul_b = 34'(v1); end
          5'd8:  begin mac_sub = 1'b1; mul_a = qy; mul_b = 34'(v0); end
          5'd9:  begin mac_clr = 1'b1; mul_a = v0; mul_b = s_term; end
          5'd10: begin mul_a = qx; mul_b = dot;   mac_sh = 4'd1; end
          5'd11: begin mul_a = qw; mul_b = cr[0]; mac_sh = 4'd1; end
          5'd12: begin mac_clr = 1'b1; mul_a = v1; mul_b = s_term; end
          5'd13: begin mul_a = qy; mul_b = dot;   mac_sh = 4'd1; end
          5'd14: begin mul_a = qw; mul_b = cr[1]; mac_sh = 4'd1; end
          5'd15: begin mac_clr = 1'b1; mul_a = v2; mul_b = s_term; end
          5'd16: begin mul_a = qz; mul_b = dot;   mac_sh = 4'd1; end
          5'd17: begin mul_a = qw; mul_b = cr[2]; mac_sh = 4'd1; end
          default: begin
            mac_en     = 1'b0;
            state_next = S_NORM;
          end
        endcase
      end
      // Shift the magnitudes until the largest lies in [2^29, 2^30)
      S_NORM: begin
        step_next = '0;
        if (a_zero) begin
          if (k == ROW_FWD) begin
            k_next     = ROW_UP;
            state_next = S_ROT;
          end else begin
            state_next = S_CROSS;
          end
        end else if (!a_high && !a_low) begin
          state_next = S_SQ;
        end
      end
      // a^2 = (a_hi * a) << 15 + a_lo * a for each component
      S_SQ: begin
        if (step == 5'd6) begin
          step_next  = '0;
          state_next = S_SQRT;
        end else begin
          mac_en  = 1'b1;
          mac_clr = (step == 5'd0);
          mul_b   = {4'd0, a_sel[29:0]};
          if (step[0]) begin
            mul_a = {1'b0, a_sel[14:0]};
          end else begin
            mul_a  = {1'b0, a_sel[29:15]};
            mac_sh = 4'd15;
          end
        end
      end
      S_SQRT: begin
        if (step == 5'd31) begin
          step_next  = '0;
          ci_next    = '0;
          state_next = S_DIV;
        end
      end
      // Load, sixteen quotient bits, write back
      S_DIV: begin
        if (step == 5'd17) begin
          step_next = '0;
          if (ci == 2'd2) begin
            if (k == ROW_FWD) begin
              k_next     = ROW_UP;
              state_next = S_ROT;
            end else begin
              state_next = S_CROSS;
            end
          end else begin
            ci_next = ci + 2'd1;
          end
        end
      end
      // right = up x forward
      S_CROSS: begin
        mac_en = 1'b1;
        case (step)
          5'd0: begin mac_clr = 1'b1; mul_a = axis[1][1]; mul_b = 34'(axis[2][2]); end
          5'd1: begin mac_sub = 1'b1; mul_a = axis[1][2]; mul_b = 34'(axis[2][1]); end
          5'd2: begin mac_clr = 1'b1; mul_a = axis[1][2]; mul_b = 34'(axis[2][0]); end
          5'd3: begin mac_sub = 1'b1; mul_a = axis[1][0]; mul_b = 34'(axis[2][2]); end
          5'd4: begin mac_clr = 1'b1; mul_a = axis[1][0]; mul_b = 34'(axis[2][1]); end
          5'd5: begin mac_sub = 1'b1; mul_a = axis[1][1]; mul_b = 34'(axis[2][0]); end
          default: begin
            mac_en     = 1'b0;
            step_next  = '0;
            row_next   = ROW_RIGHT;
            state_next = S_EMIT;
          end
        endcase
      end
      // dot(axis, position), then hand the row to the output register
      S_EMIT: begin
        case (step)
          5'd0: begin mac_en = 1'b1; mac_clr = 1'b1; mul_a = v0; mul_b = 34'(pos[0]); end
          5'd1: begin mac_en = 1'b1; mul_a = v1; mul_b = 34'(pos[1]); end
          5'd2: begin mac_en = 1'b1; mul_a = v2; mul_b = 34'(pos[2]); end
          default: begin
            step_next = step;
            if (!m_tvalid || m_tready) begin
              out_load  = 1'b1;
              step_next = '0;
              if (row == ROW_FWD) state_next = S_IDLE;
              else row_next = row + 2'd1;
            end
          end
        endcase
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control, configuration and pose
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      step           <= '0;
      k              <= ROW_FWD;
      ci             <= '0;
      row            <= ROW_RIGHT;
      m_tvalid       <= 1'b0;
      start_x        <= '0;
      start_y        <= '0;
      start_z        <= '0;
      zero_threshold <= 16'd1;
      pos[0]         <= '0;
      pos[1]         <= '0;
      pos[2]         <= '0;
      axis[0][0] <= AXIS_ONE; axis[0][1] <= '0;       axis[0][2] <= '0;
      axis[1][0] <= '0;       axis[1][1] <= AXIS_ONE; axis[1][2] <= '0;
      axis[2][0] <= '0;       axis[2][1] <= '0;       axis[2][2] <= AXIS_ONE;
    end else begin
      state <= state_next;
      step  <= step_next;
      k     <= k_next;
      ci    <= ci_next;
      row   <= row_next;

      if (out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;

      if (cfg_wen) begin
        case (cfg_index)
          REG_START_X: start_x        <= cfg_data;
          REG_START_Y: start_y        <= cfg_data;
          REG_START_Z: start_z        <= cfg_data;
          default:     zero_threshold <= cfg_data[15:0];
        endcase
      end

      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            case (s_tuser)
              MODE_TRANSLATE: begin
                pos[0] <= sat_add(pos[0], s_tdata[31:0]);
                pos[1] <= sat_add(pos[1], s_tdata[63:32]);
                pos[2] <= sat_add(pos[2], s_tdata[95:64]);
              end
              MODE_RESTORE: begin
                pos[0] <= start_x;
                pos[1] <= start_y;
                pos[2] <= start_z;
                axis[0][0] <= AXIS_ONE; axis[0][1] <= '0;       axis[0][2] <= '0;
                axis[1][0] <= '0;       axis[1][1] <= AXIS_ONE; axis[1][2] <= '0;
                axis[2][0] <= '0;       axis[2][1] <= '0;       axis[2][2] <= AXIS_ONE;
              end
              default: ;
            endcase
          end
        end
        S_DIV: begin
          if (step == 5'd17) axis[k][ci] <= sgn_sel ? -$signed(dq) : $signed(dq);
        end
        S_CROSS: begin
          case (step)
            5'd2: axis[0][0] <= sat16(rnd14(acc));
            5'd4: axis[0][1] <= sat16(rnd14(acc));
            5'd6: axis[0][2] <= sat16(rnd14(acc));
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  // Datapath and output payload
  always_ff @(posedge clk) begin
    if (mac_en) acc <= acc_next;
    if (out_load) begin
      m_tdata <= {sat32(rnd14(-acc)), v2, v1, v0};
      m_tuser <= row;
      m_tlast <= (row == ROW_FWD);
    end
    case (state)
      S_IDLE: begin
        qw <= s_tdata[111:96];
        qx <= s_tdata[127:112];
        qy <= s_tdata[143:128];
        qz <= s_tdata[159:144];
      end
      S_LEN: begin
        if (step == 5'd3) sq3 <= acc[33:0];
      end
      S_CHECK: s_term <= 34'(acc - 64'(sq3));
      S_ROT: begin
        case (step)
          5'd3:  dot   <= acc[33:0];
          5'd5:  cr[0] <= acc[33:0];
          5'd7:  cr[1] <= acc[33:0];
          5'd9:  cr[2] <= acc[33:0];
          5'd12: begin a[0] <= acc_abs[ABS_W-1:0]; sgn[0] <= acc[63]; end
          5'd15: begin a[1] <= acc_abs[ABS_W-1:0]; sgn[1] <= acc[63]; end
          5'd18: begin a[2] <= acc_abs[ABS_W-1:0]; sgn[2] <= acc[63]; end
          default: ;
        endcase
      end
      S_NORM: begin
        if (a_high) begin
          a[0] <= a[0] >> 1;
          a[1] <= a[1] >> 1;
          a[2] <= a[2] >> 1;
        end else if (a_low) begin
          a[0] <= a[0] << 1;
          a[1] <= a[1] << 1;
          a[2] <= a[2] << 1;
        end
      end
      S_SQ: begin
        if (step == 5'd6) begin
          rem  <= acc;
          res  <= '0;
          sbit <= 64'h4000_0000_0000_0000;
        end
      end
      S_SQRT: begin
        if (rem >= sq_t) begin
          rem <= rem - sq_t;
          res <= (res >> 1) + sbit;
        end else begin
          res <= res >> 1;
        end
        sbit <= sbit >> 2;
      end
      S_DIV: begin
        if (step == 5'd0) begin
          drem <= 32'(num[44:16]);
          dlo  <= num[15:0];
          dq   <= '0;
        end else if (step != 5'd17) begin
          if (div_t >= {1'b0, res[31:0]}) begin
            drem <= 32'(div_t - {1'b0, res[31:0]});
            dq   <= {dq[14:0], 1'b1};
          end else begin
            drem <= div_t[31:0];
            dq   <= {dq[14:0], 1'b0};
          end
          dlo <= dlo << 1;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

/* src/cpvm_checker.sv */
// Port-level checks for camera_pose_view_matrix and the bind that attaches them.
// Depends on cpvm_pkg and the top level's port names.
`default_nettype none
module cpvm_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [cpvm_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic [1:0]                      m_tuser,
  input logic                            m_tlast
);
  import cpvm_pkg::*;

  // Hold a stalled output transfer
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                              && $stable(m_tlast))
    else $error("output changed while stalled");

  // Mark only the forward row as last
  a_last_row: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == (m_tuser == ROW_FWD)))
    else $error("tlast does not match the forward row");

  // Drop ready once an input is taken
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while busy");

  // Stay busy while a row before the forward one is still held
  a_rows_pending: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> !s_tready)
    else $error("ready while rows of the matrix are outstanding");

endmodule

bind camera_pose_view_matrix cpvm_checker u_cpvm_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
`default_nettype wire

/* verif/tb_camera_pose_view_matrix.sv */
// Self-checking testbench for camera_pose_view_matrix: drives pose commands on the
// input stream, predicts the three view-matrix rows of each command, checks the outputs.
// Depends on cpvm_pkg and the RTL top level.
`default_nettype none
module tb_camera_pose_view_matrix;
  timeunit 1ns;
  timeprecision 1ps;
  import cpvm_pkg::*;

  typedef longint vec3_t [3];

  // One expected view-matrix row, as it shows up on the output stream.
  typedef struct {
    logic [1:0]         row;
    logic signed [15:0] col_x;
    logic signed [15:0] col_y;
    logic signed [15:0] col_z;
    logic signed [31:0] offset;
    logic               last;
  } view_row_t;

  localparam longint I32_MIN = -64'sd2147483648;
  localparam longint I32_MAX = 64'sd2147483647;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  // delta_x, delta_y, delta_z, quat_w, quat_x, quat_y, quat_z (lowest bits first)
  logic [IN_DATA_W-1:0]  s_tdata;
  // mode
  logic [1:0]            s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  // col_x, col_y, col_z, offset (lowest bits first)
  logic [OUT_DATA_W-1:0] m_tdata;
  // row_index
  logic [1:0]            m_tuser;
  logic                  m_tlast;
  logic                  cfg_wen;
  logic [1:0]            cfg_index;
  logic [CFG_W-1:0]      cfg_data;

  camera_pose_view_matrix DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predicted pose and configuration.
  longint    start_pos [3];
  longint    zero_thr;
  vec3_t     cam_pos;
  vec3_t     right_ax;
  vec3_t     up_ax;
  vec3_t     fwd_ax;

  view_row_t pending_rows [$];
  int        mismatches;
  int        rows_checked;
  int        cmds_sent;
  int        rotates_sent;
  bit        no_idle;   // when set, both sides run without gaps or stalls

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Limit: far beyond the slowest legal run of about 400 commands.
  initial begin
    #5ms;
    $display("timeout with %0d rows still pending", pending_rows.size());
    $display("FAIL camera_pose_view_matrix");
    $finish;
  end

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 11);
  endfunction

  // ---------------------------------------------------------------- prediction

  function automatic longint clamp_to(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // Shift right with round to nearest, ties away from zero.
  function automatic longint round_away(longint v, int sh);
    longint unsigned m;
    m = v < 0 ? -v : v;
    m = (m + (64'd1 << (sh - 1))) >> sh;
    return v < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Rotate one axis by q*v*conj(q) and renormalize to Q2.14; a zero result keeps v.
  function automatic vec3_t rotate_unit(vec3_t v, longint w, longint x, longint y, longint z);
    longint          dotuv, s;
    longint          cr [3];
    longint          c [3];
    longint unsigned a [3];
    longint unsigned mx, sum, len, q;
    vec3_t           res;
    dotuv = x * v[0] + y * v[1] + z * v[2];
    s = w * w - (x * x + y * y + z * z);
    cr[0] = y * v[2] - z * v[1];
    cr[1] = z * v[0] - x * v[2];
    cr[2] = x * v[1] - y * v[0];
    c[0] = s * v[0] + 2 * x * dotuv + 2 * w * cr[0];
    c[1] = s * v[1] + 2 * y * dotuv + 2 * w * cr[1];
    c[2] = s * v[2] + 2 * z * dotuv + 2 * w * cr[2];
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      a[i] = c[i] < 0 ? -c[i] : c[i];
      if (a[i] > mx) mx = a[i];
    end
    if (mx == 0) return v;
    // Bring the largest magnitude into [2^29, 2^30).
    while (mx >= (64'd1 << 30)) begin
      mx = mx >> 1;
      for (int i = 0; i < 3; i++) a[i] = a[i] >> 1;
    end
    while (mx < (64'd1 << 29)) begin
      mx = mx << 1;
      for (int i = 0; i < 3; i++) a[i] = a[i] << 1;
    end
    sum = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
    len = int_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      q = (a[i] * 64'd16384 + len / 2) / len;
      res[i] = c[i] < 0 ? -longint'(q) : longint'(q);
    end
    return res;
  endfunction

  function automatic longint cross_term(longint p, longint q, longint r, longint t);
    return clamp_to(round_away(p * q - r * t, 14), -32768, 32767);
  endfunction

  function automatic view_row_t make_row(logic [1:0] row, vec3_t ax);
    view_row_t r;
    longint    acc;
    acc = -(ax[0] * cam_pos[0] + ax[1] * cam_pos[1] + ax[2] * cam_pos[2]);
    r.row    = row;
    r.col_x  = ax[0][15:0];
    r.col_y  = ax[1][15:0];
    r.col_z  = ax[2][15:0];
    r.offset = 32'(clamp_to(round_away(acc, 14), I32_MIN, I32_MAX));
    r.last   = (row == ROW_FWD);
    return r;
  endfunction

  function automatic void restore_pose();
    for (int i = 0; i < 3; i++) begin
      cam_pos[i]  = start_pos[i];
      right_ax[i] = 0;
      up_ax[i]    = 0;
      fwd_ax[i]   = 0;
    end
    right_ax[0] = AXIS_ONE;
    up_ax[1]    = AXIS_ONE;
    fwd_ax[2]   = AXIS_ONE;
  endfunction

  // Advance the pose by one accepted command and queue its three rows.
  function automatic void apply_pose_cmd(logic [1:0] mode, logic [IN_DATA_W-1:0] d);
    longint w, x, y, z;
    case (mode)
      MODE_TRANSLATE: begin
        for (int i = 0; i < 3; i++)
          cam_pos[i] = clamp_to(cam_pos[i] + longint'($signed(d[32*i +: 32])), I32_MIN, I32_MAX);
      end
      MODE_ROTATE: begin
        w = $signed(d[96 +: 16]);
        x = $signed(d[112 +: 16]);
        y = $signed(d[128 +: 16]);
        z = $signed(d[144 +: 16]);
        if (w * w + x * x + y * y + z * z >= zero_thr) begin
          fwd_ax = rotate_unit(fwd_ax, w, x, y, z);
          up_ax  = rotate_unit(up_ax, w, x, y, z);
          right_ax[0] = cross_term(up_ax[1], fwd_ax[2], up_ax[2], fwd_ax[1]);
          right_ax[1] = cross_term(up_ax[2], fwd_ax[0], up_ax[0], fwd_ax[2]);
          right_ax[2] = cross_term(up_ax[0], fwd_ax[1], up_ax[1], fwd_ax[0]);
        end
      end
      MODE_RESTORE: restore_pose();
      default: ;  // mode three leaves the pose alone
    endcase
    pending_rows.push_back(make_row(ROW_RIGHT, right_ax));
    pending_rows.push_back(make_row(ROW_UP, up_ax));
    pending_rows.push_back(make_row(ROW_FWD, fwd_ax));
  endfunction

  // ---------------------------------------------------------------- driving

  // Send one command; start and end on a rising edge.
  task automatic send_pose_cmd(logic [1:0] mode, logic [31:0] dx, logic [31:0] dy,
                               logic [31:0] dz, logic [15:0] qw, logic [15:0] qx,
                               logic [15:0] qy, logic [15:0] qz);
    repeat (draw_gap() + 1) @(posedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {qz, qy, qx, qw, dz, dy, dx};
    do @(posedge clk); while (!s_tready);
    apply_pose_cmd(mode, {qz, qy, qx, qw, dz, dy, dx});
    s_tvalid <= 1'b0;
    cmds_sent++;
    if (mode == MODE_ROTATE) rotates_sent++;
  endtask

  task automatic translate(longint dx, longint dy, longint dz);
    send_pose_cmd(MODE_TRANSLATE, dx[31:0], dy[31:0], dz[31:0], '0, '0, '0, '0);
  endtask

  task automatic rotate(int qw, int qx, int qy, int qz);
    send_pose_cmd(MODE_ROTATE, $urandom, $urandom, $urandom,
                  qw[15:0], qx[15:0], qy[15:0], qz[15:0]);
  endtask

  // Hold until every predicted row is out, then let the sequencer settle.
  task automatic wait_drained();
    while (pending_rows.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_wen <= 1'b0;
    case (idx)
      REG_START_X:  start_pos[0] = longint'($signed(value));
      REG_START_Y:  start_pos[1] = longint'($signed(value));
      REG_START_Z:  start_pos[2] = longint'($signed(value));
      REG_ZERO_THR: zero_thr = value[15:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Random command with random content; mostly translate and rotate.
  task automatic random_cmd();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 8) begin
      if ($urandom_range(0, 5) == 0)
        send_pose_cmd(MODE_TRANSLATE, $urandom, $urandom, $urandom, '0, '0, '0, '0);
      else
        translate(longint'($urandom_range(0, 2**21)) - 2**20,
                  longint'($urandom_range(0, 2**21)) - 2**20,
                  longint'($urandom_range(0, 2**21)) - 2**20);
    end else if (pick < 17) begin
      if ($urandom_range(0, 4) == 0)
        rotate($urandom_range(0, 31) - 16, $urandom_range(0, 31) - 16,
               $urandom_range(0, 31) - 16, $urandom_range(0, 31) - 16);
      else
        send_pose_cmd(MODE_ROTATE, $urandom, $urandom, $urandom,
                      16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    end else if (pick < 19) begin
      send_pose_cmd(MODE_RESTORE, $urandom, $urandom, $urandom,
                    16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    end else begin
      send_pose_cmd(MODE_HOLD, $urandom, $urandom, $urandom,
                    16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    end
  endtask

  task automatic random_run(int n);
    for (int i = 0; i < n; i++) begin
      // Drop into gap-free stretches now and then.
      if (i % 30 == 0) no_idle = ($urandom_range(0, 3) == 0);
      random_cmd();
    end
    no_idle = 1'b0;
  endtask

  // ---------------------------------------------------------------- checking

  always @(posedge clk) begin
    view_row_t exp_row;
    int        stall;
    if (rst) begin
      m_tready <= 1'b0;
      stall = 0;
    end else if (m_tvalid && m_tready) begin
      rows_checked++;
      if (pending_rows.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%t unexpected row %0d, data %h", $realtime, m_tuser, m_tdata);
      end else begin
        exp_row = pending_rows.pop_front();
        if (m_tuser !== exp_row.row || m_tlast !== exp_row.last ||
            m_tdata[15:0] !== exp_row.col_x || m_tdata[31:16] !== exp_row.col_y ||
            m_tdata[47:32] !== exp_row.col_z || m_tdata[79:48] !== exp_row.offset) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%t row mismatch: exp row %0d last %0d axis (%0d %0d %0d) off %0d;%s",
                     $realtime, exp_row.row, exp_row.last, exp_row.col_x, exp_row.col_y,
                     exp_row.col_z, exp_row.offset, "");
          if (mismatches <= 10)
            $display("             got row %0d last %0d axis (%0d %0d %0d) off %0d",
                     m_tuser, m_tlast, $signed(m_tdata[15:0]), $signed(m_tdata[31:16]),
                     $signed(m_tdata[47:32]), $signed(m_tdata[79:48]));
        end
      end
      stall = draw_gap();
      m_tready <= (stall == 0);
    end else if (stall > 0) begin
      stall--;
      m_tready <= (stall == 0);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- tests

  task automatic test_translate_edges();
    translate(64'sh10000, -64'sh10000, 64'sh8000);
    translate(I32_MAX, I32_MAX, I32_MAX);   // saturate high
    translate(I32_MAX, 1, I32_MAX);
    translate(I32_MIN, I32_MIN, I32_MIN);
    translate(I32_MIN, I32_MIN, I32_MIN);   // saturate low
    translate(I32_MIN, -1, 0);
    send_pose_cmd(MODE_HOLD, '1, '1, '1, '1, '1, '1, '1);  // mode three: no change
    send_pose_cmd(MODE_RESTORE, '1, '1, '1, '1, '1, '1, '1);
  endtask

  task automatic test_rotate_edges();
    translate(64'sh30000, -64'sh50000, 64'sh12345);
    rotate(16384, 0, 0, 0);                  // identity
    rotate(11585, 0, 0, 11585);              // quarter turn about z
    rotate(100, 0, 50, 0);                   // short but above threshold
    rotate(-32768, 32767, -32768, 32767);    // field extremes
    rotate(0, 0, 0, 0);                      // below default threshold: ignored
    rotate(0, -32768, 0, 0);                 // half turn
    rotate(1, 0, 0, 0);                      // smallest accepted quaternion
    wait_drained();
    write_reg(REG_ZERO_THR, 32'd0);
    rotate(0, 0, 0, 0);                      // zero rotated vector keeps the axes
    wait_drained();
    write_reg(REG_ZERO_THR, 32'd65535);
    rotate(181, 181, 0, 0);                  // 65522: ignored
    rotate(256, 0, 0, 0);                    // 65536: taken
    rotate(128, 0, 128, 0);                  // ignored
    send_pose_cmd(MODE_RESTORE, '0, '0, '0, '0, '0, '0, '0);
    wait_drained();
  endtask

  task automatic test_start_position(longint sx, longint sy, longint sz, int thr, int n);
    write_reg(REG_START_X, sx[31:0]);
    write_reg(REG_START_Y, sy[31:0]);
    write_reg(REG_START_Z, sz[31:0]);
    write_reg(REG_ZERO_THR, thr);
    translate(64'sh100, 64'sh100, 64'sh100);  // start moves nothing until a restore
    send_pose_cmd(MODE_RESTORE, '0, '0, '0, '0, '0, '0, '0);
    random_run(n);
    wait_drained();
  endtask

  task automatic test_drain_pause();
    random_run(20);
    wait_drained();   // sender holds until every row is out
    random_run(20);
    wait_drained();
  endtask

  initial begin
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = '0;
    cfg_wen   = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    mismatches   = 0;
    rows_checked = 0;
    cmds_sent    = 0;
    rotates_sent = 0;
    no_idle      = 1'b0;
    start_pos[0] = 0;
    start_pos[1] = 0;
    start_pos[2] = 0;
    zero_thr     = 1;
    restore_pose();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_translate_edges();
    test_rotate_edges();
    test_start_position(64'sh7fff_0000, -64'sh8000_0000, 64'sh1234_5678, 1, 100);
    test_start_position(I32_MAX, I32_MIN, 0, 0, 60);
    test_start_position(-64'sh0001_8000, 64'sh0042_0000, I32_MAX, 65535, 60);
    test_start_position(0, 0, 0, 1, 90);
    test_drain_pause();

    repeat (400) @(posedge clk);
    $display("covered %0d commands (%0d rotations), %0d rows compared, %0d mismatches",
             cmds_sent, rotates_sent, rows_checked, mismatches);
    if (mismatches == 0 && pending_rows.size() == 0) begin
      $display("PASS camera_pose_view_matrix");
    end else begin
      $display("FAIL camera_pose_view_matrix");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* filelist.f */
src/cpvm_pkg.sv
src/camera_pose_view_matrix.sv
src/cpvm_checker.sv
verif/tb_camera_pose_view_matrix.sv
